@@ src/tct_pkg.sv @@
// ----------------------------------------------------------------------------
// tct_pkg
// Shared types, register indexes, factor tables and small color helpers
// for the tile color tint pipeline.
// ----------------------------------------------------------------------------
package tct_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_BLOCKING   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGHLIGHT_ITEMS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_SPAWNS     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_HOUSES     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_SPECIAL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_HOUSE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LEVEL     = 3'd6;

	localparam int FL_BLOCKING = 0;
	localparam int FL_CONTENT  = 1;
	localparam int FL_BORDER   = 2;
	localparam int FL_HOUSE    = 3;
	localparam int FL_PZ       = 4;
	localparam int FL_PVP      = 5;
	localparam int FL_NOLOGOUT = 6;
	localparam int FL_NOPVP    = 7;

	localparam logic [7:0]  BLOCK_FACTOR = 8'd171;
	localparam logic [31:0] HASH_MUL     = 32'h045d_9f3b;
	localparam logic [7:0]  DIM_LIMIT    = 8'd50;
	localparam logic [7:0]  DIM_BOOST    = 8'd100;
	localparam logic [7:0]  PULSE_GAIN   = 8'd154;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	typedef struct packed {
		logic ld1;
		logic ld2;
		logic ld3;
	} hash_en_t;

	function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] f);
		logic [15:0] p;
		p = 16'(c) * 16'(f);
		return p[15:8];
	endfunction

	function automatic logic [31:0] hash_fold(input logic [31:0] h);
		return (h >> 16) ^ h;
	endfunction

	function automatic logic [7:0] item_factor(input logic [7:0] n);
		logic [7:0] f;
		unique case (n)
			8'd1:    f = 8'd192;
			8'd2:    f = 8'd154;
			8'd3:    f = 8'd123;
			8'd4:    f = 8'd102;
			default: f = 8'd84;
		endcase
		return f;
	endfunction

	function automatic logic [7:0] spawn_scale(input logic [7:0] n);
		logic [7:0] f;
		unique case (n)
			8'd1:    f = 8'd179;
			8'd2:    f = 8'd125;
			8'd3:    f = 8'd88;
			8'd4:    f = 8'd61;
			8'd5:    f = 8'd43;
			8'd6:    f = 8'd30;
			8'd7:    f = 8'd21;
			8'd8:    f = 8'd15;
			default: f = 8'd10;
		endcase
		return f;
	endfunction

endpackage

@@ src/tct_house_hash.sv @@
// ----------------------------------------------------------------------------
// tct_house_hash
// Three-stage hash of the house id into a per-house tint color, aligned
// with the first three stages of the tint pipeline.
// ----------------------------------------------------------------------------
module tct_house_hash (
	input  logic              clk,
	input  tct_pkg::hash_en_t en,
	input  logic [31:0]       house_key,
	output tct_pkg::rgb_t     house_color
);
	import tct_pkg::*;

	logic [31:0] prod1, prod2;
	logic [31:0] h1_s1, h2_s2, h3;
	rgb_t        hc, hc_s3;

	assign prod1 = hash_fold(house_key) * HASH_MUL;
	assign prod2 = hash_fold(h1_s1) * HASH_MUL;
	assign h3    = hash_fold(h2_s2);

	always_comb begin
		hc.r = h3[7:0];
		hc.g = h3[15:8];
		hc.b = h3[23:16];
		if (hc.r < DIM_LIMIT && hc.g < DIM_LIMIT && hc.b < DIM_LIMIT) begin
			hc.r = hc.r + DIM_BOOST;
			hc.g = hc.g + DIM_BOOST;
			hc.b = hc.b + DIM_BOOST;
		end
	end

	always_ff @(posedge clk) begin
		if (en.ld1) h1_s1 <= prod1;
		if (en.ld2) h2_s2 <= prod2;
		if (en.ld3) hc_s3 <= hc;
	end

	assign house_color = hc_s3;

endmodule

@@ src/tile_color_tint_unit.sv @@
// ----------------------------------------------------------------------------
// tile_color_tint_unit
// Tints one tile's RGB by blocking, item, spawn, house, pulse and zone rules.
// Path: an accepted input beat is registered through stages s1 to s7 to its output beat.
// Throughput: one beat per cycle while tint_ready allows; each of the 7 stages
// stalls on its own, so bubbles are squeezed out while the output waits.
// Reset: stage valids and all configuration registers clear to zero.
// ----------------------------------------------------------------------------
module tile_color_tint_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tct_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tct_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          tile_valid,
	output logic                          tile_ready,
	input  logic [7:0]                    red_in,
	input  logic [7:0]                    green_in,
	input  logic [7:0]                    blue_in,
	input  logic [7:0]                    tile_flags,
	input  logic [7:0]                    stack_count,
	input  logic [7:0]                    spawn_total,
	input  logic [31:0]                   tile_house,
	output logic                          tint_valid,
	input  logic                          tint_ready,
	output logic [7:0]                    red_out,
	output logic [7:0]                    green_out,
	output logic [7:0]                    blue_out
);
	import tct_pkg::*;

	logic        show_blocking_q, highlight_items_q, show_spawns_q;
	logic        show_houses_q, show_special_q;
	logic [31:0] current_house_q;
	logic [8:0]  pulse_level_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	rgb_t       col_s1, col_s2, col_s3, col_s4, col_s5, col_s6, col_s7;
	logic [7:0] flags_s1, flags_s2, flags_s3, flags_s4, flags_s5, flags_s6;
	logic [7:0] items_s1, spawns_s1, spawns_s2;
	logic       hit_s1, hit_s2, hit_s3;
	logic       pulse_s4, pulse_s5;
	logic [16:0] tr_s5, tg_s5, tb_s5;

	rgb_t       col1, col2, col3, col4, col6, col7, hc;
	logic [16:0] tr, tg, tb;
	hash_en_t   hen;

	assign en7 = !v_s7 || tint_ready;
	assign en6 = !v_s6 || en7;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign tile_ready = en1;

	assign hen.ld1 = en1;
	assign hen.ld2 = en2;
	assign hen.ld3 = en3;

	tct_house_hash u_hash (
		.clk        (clk),
		.en         (hen),
		.house_key  (tile_house),
		.house_color(hc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			show_blocking_q   <= 1'b0;
			highlight_items_q <= 1'b0;
			show_spawns_q     <= 1'b0;
			show_houses_q     <= 1'b0;
			show_special_q    <= 1'b0;
			current_house_q   <= '0;
			pulse_level_q     <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SHOW_BLOCKING:   show_blocking_q   <= cfg_data[0];
				CFG_HIGHLIGHT_ITEMS: highlight_items_q <= cfg_data[0];
				CFG_SHOW_SPAWNS:     show_spawns_q     <= cfg_data[0];
				CFG_SHOW_HOUSES:     show_houses_q     <= cfg_data[0];
				CFG_SHOW_SPECIAL:    show_special_q    <= cfg_data[0];
				CFG_CURRENT_HOUSE:   current_house_q   <= cfg_data[31:0];
				CFG_PULSE_LEVEL:     pulse_level_q     <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// blocking darken
	always_comb begin
		col1.r = red_in;
		col1.g = green_in;
		col1.b = blue_in;
		if (show_blocking_q && tile_flags[FL_BLOCKING] && tile_flags[FL_CONTENT]) begin
			col1.g = scale8(green_in, BLOCK_FACTOR);
			col1.b = scale8(blue_in, BLOCK_FACTOR);
		end
	end

	// item-count darken
	always_comb begin
		col2 = col_s1;
		if (highlight_items_q && items_s1 != 8'd0 && !flags_s1[FL_BORDER]) begin
			col2.r = scale8(col_s1.r, item_factor(items_s1));
			col2.g = scale8(col_s1.g, item_factor(items_s1));
		end
	end

	// spawn-count darken
	always_comb begin
		col3 = col_s2;
		if (show_spawns_q && spawns_s2 != 8'd0) begin
			col3.g = scale8(col_s2.g, spawn_scale(spawns_s2));
			col3.b = scale8(col_s2.b, spawn_scale(spawns_s2));
		end
	end

	// house tint, else protection-zone halving
	always_comb begin
		logic [15:0] pr, pg, pb;
		pr = 16'(col_s3.r) * 16'(hc.r) + 16'(col_s3.r);
		pg = 16'(col_s3.g) * 16'(hc.g) + 16'(col_s3.g);
		pb = 16'(col_s3.b) * 16'(hc.b) + 16'(col_s3.b);
		col4 = col_s3;
		if (show_houses_q && flags_s3[FL_HOUSE]) begin
			col4.r = pr[15:8];
			col4.g = pg[15:8];
			col4.b = pb[15:8];
		end else if (show_special_q && flags_s3[FL_PZ]) begin
			col4.r = col_s3.r >> 1;
			col4.b = col_s3.b >> 1;
		end
	end

	assign tr = 17'(8'd255 - col_s4.r) * 17'(pulse_level_q);
	assign tg = 17'(8'd255 - col_s4.g) * 17'(pulse_level_q);
	assign tb = 17'(8'd255 - col_s4.b) * 17'(pulse_level_q);

	function automatic logic [7:0] pulse_add(input logic [7:0] c, input logic [16:0] t);
		logic [24:0] p;
		logic [9:0]  s;
		p = 25'(t) * 25'(PULSE_GAIN);
		s = 10'(c) + 10'(p[24:16]);
		return (s > 10'd255) ? 8'd255 : s[7:0];
	endfunction

	always_comb begin
		col6 = col_s5;
		if (pulse_s5) begin
			col6.r = pulse_add(col_s5.r, tr_s5);
			col6.g = pulse_add(col_s5.g, tg_s5);
			col6.b = pulse_add(col_s5.b, tb_s5);
		end
	end

	// zone flag adjustments
	always_comb begin
		col7 = col_s6;
		if (show_special_q && flags_s6[FL_PVP]) begin
			col7.g = col_s6.r >> 2;
			col7.b = scale8(col_s6.b, BLOCK_FACTOR);
		end
		if (show_special_q && flags_s6[FL_NOLOGOUT]) col7.b = col7.b >> 1;
		if (show_special_q && flags_s6[FL_NOPVP])    col7.g = col7.g >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en1) v_s1 <= tile_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			col_s1    <= col1;
			flags_s1  <= tile_flags;
			items_s1  <= stack_count;
			spawns_s1 <= spawn_total;
			hit_s1    <= (tile_house == current_house_q);
		end
		if (en2) begin
			col_s2    <= col2;
			flags_s2  <= flags_s1;
			spawns_s2 <= spawns_s1;
			hit_s2    <= hit_s1;
		end
		if (en3) begin
			col_s3   <= col3;
			flags_s3 <= flags_s2;
			hit_s3   <= hit_s2;
		end
		if (en4) begin
			col_s4   <= col4;
			flags_s4 <= flags_s3;
			pulse_s4 <= show_houses_q && flags_s3[FL_HOUSE] && hit_s3
				&& (pulse_level_q != 9'd0);
		end
		if (en5) begin
			col_s5   <= col_s4;
			flags_s5 <= flags_s4;
			pulse_s5 <= pulse_s4;
			tr_s5    <= tr;
			tg_s5    <= tg;
			tb_s5    <= tb;
		end
		if (en6) begin
			col_s6   <= col6;
			flags_s6 <= flags_s5;
		end
		if (en7) col_s7 <= col7;
	end

	assign tint_valid = v_s7;
	assign red_out    = col_s7.r;
	assign green_out  = col_s7.g;
	assign blue_out   = col_s7.b;

endmodule

@@ verif/tile_color_tint_unit_test.sv @@
// ----------------------------------------------------------------------------
// tile_color_tint_unit_test
// Self-checking bench for the tile color tint pipeline. A table of directed
// tiles covers the color and count extremes, each flag rule, the dim house
// color boost and pulses at and above full strength. After that come random
// tiles under a series of register settings. Every output beat is compared
// channel by channel with a table color or a local model of the tint rules.
// The sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tile_color_tint_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	import tct_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef struct packed {
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [7:0]  fl;
		logic [7:0]  items;
		logic [7:0]  spawns;
		logic [31:0] hid;
	} tile_t;

	typedef enum {SET_RESET, SET_FULL, SET_HOT} dir_set_t;

	typedef struct {
		tile_t    t;
		dir_set_t setup;
		bit       typed;
		rgb_t     want;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  tile_valid;
	logic                  tile_ready;
	logic [7:0]            red_in;
	logic [7:0]            green_in;
	logic [7:0]            blue_in;
	logic [7:0]            tile_flags;
	logic [7:0]            stack_count;
	logic [7:0]            spawn_total;
	logic [31:0]           tile_house;
	logic                  tint_valid;
	logic                  tint_ready;
	logic [7:0]            red_out;
	logic [7:0]            green_out;
	logic [7:0]            blue_out;

	bit          cfg_blocking;
	bit          cfg_items;
	bit          cfg_spawns;
	bit          cfg_houses;
	bit          cfg_special;
	logic [31:0] cfg_house;
	logic [8:0]  cfg_pulse;

	rgb_t        tint_expected[$];
	dir_row_t    dir_rows[$];
	bit          exp_typed;
	rgb_t        exp_rgb;
	bit          tile_up;
	int          burst_left;
	int          mismatches;
	logic [31:0] dim_id;

	tile_color_tint_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.tile_valid (tile_valid),
		.tile_ready (tile_ready),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.tile_flags (tile_flags),
		.stack_count(stack_count),
		.spawn_total(spawn_total),
		.tile_house (tile_house),
		.tint_valid (tint_valid),
		.tint_ready (tint_ready),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	function automatic logic [31:0] house_hash(logic [31:0] id);
		logic [31:0] h;
		h = ((id >> 16) ^ id) * 32'h045d_9f3b;
		h = ((h >> 16) ^ h) * 32'h045d_9f3b;
		return (h >> 16) ^ h;
	endfunction

	function automatic logic [31:0] pulse_up(logic [31:0] c);
		logic [31:0] v;
		v = c + (((32'd255 - c) * 32'(cfg_pulse) * 32'd154) >> 16);
		return (v > 32'd255) ? 32'd255 : v;
	endfunction

	function automatic rgb_t tint_predict(tile_t t);
		logic [31:0] r, g, b, f, h, hr, hg, hb;
		rgb_t o;
		r = 32'(t.r);
		g = 32'(t.g);
		b = 32'(t.b);
		if (cfg_blocking && t.fl[FL_BLOCKING] && t.fl[FL_CONTENT]) begin
			g = (g * 32'd171) >> 8;
			b = (b * 32'd171) >> 8;
		end
		if (cfg_items && t.items != 8'd0 && !t.fl[FL_BORDER]) begin
			case (t.items)
				8'd1:    f = 32'd192;
				8'd2:    f = 32'd154;
				8'd3:    f = 32'd123;
				8'd4:    f = 32'd102;
				default: f = 32'd84;
			endcase
			g = (g * f) >> 8;
			r = (r * f) >> 8;
		end
		if (cfg_spawns && t.spawns != 8'd0) begin
			case (t.spawns)
				8'd1:    f = 32'd179;
				8'd2:    f = 32'd125;
				8'd3:    f = 32'd88;
				8'd4:    f = 32'd61;
				8'd5:    f = 32'd43;
				8'd6:    f = 32'd30;
				8'd7:    f = 32'd21;
				8'd8:    f = 32'd15;
				default: f = 32'd10;
			endcase
			g = (g * f) >> 8;
			b = (b * f) >> 8;
		end
		if (cfg_houses && t.fl[FL_HOUSE]) begin
			h = house_hash(t.hid);
			hr = 32'(h[7:0]);
			hg = 32'(h[15:8]);
			hb = 32'(h[23:16]);
			if (hr < 32'd50 && hg < 32'd50 && hb < 32'd50) begin
				hr += 32'd100;
				hg += 32'd100;
				hb += 32'd100;
			end
			r = ((r * hr + r) >> 8) & 32'hFF;
			g = ((g * hg + g) >> 8) & 32'hFF;
			b = ((b * hb + b) >> 8) & 32'hFF;
			if (t.hid == cfg_house && cfg_pulse != 9'd0) begin
				r = pulse_up(r);
				g = pulse_up(g);
				b = pulse_up(b);
			end
		end else if (cfg_special && t.fl[FL_PZ]) begin
			r = r >> 1;
			b = b >> 1;
		end
		if (cfg_special && t.fl[FL_PVP]) begin
			g = r >> 2;
			b = (b * 32'd171) >> 8;
		end
		if (cfg_special && t.fl[FL_NOLOGOUT])
			b = b >> 1;
		if (cfg_special && t.fl[FL_NOPVP])
			g = g >> 1;
		o.r = r[7:0];
		o.g = g[7:0];
		o.b = b[7:0];
		return o;
	endfunction

	task automatic store_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_SHOW_BLOCKING:   cfg_blocking = data[0];
			CFG_HIGHLIGHT_ITEMS: cfg_items    = data[0];
			CFG_SHOW_SPAWNS:     cfg_spawns   = data[0];
			CFG_SHOW_HOUSES:     cfg_houses   = data[0];
			CFG_SHOW_SPECIAL:    cfg_special  = data[0];
			CFG_CURRENT_HOUSE:   cfg_house    = data[31:0];
			CFG_PULSE_LEVEL:     cfg_pulse    = data[8:0];
			default: ;
		endcase
	endtask

	task automatic check_channel(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		tile_t t;
		rgb_t want;
		if (arst_n) begin
			if (tile_valid && tile_ready) begin
				t = '{r: red_in, g: green_in, b: blue_in, fl: tile_flags,
					items: stack_count, spawns: spawn_total, hid: tile_house};
				tint_expected.push_back(exp_typed ? exp_rgb : tint_predict(t));
			end
			if (cfg_we)
				store_reg(cfg_index, cfg_data);
			if (tint_valid && tint_ready) begin
				if (tint_expected.size() == 0) begin
					$display("%0t: output beat with nothing expected, actual %0d %0d %0d",
						$time, red_out, green_out, blue_out);
					mismatches++;
				end else begin
					want = tint_expected.pop_front();
					check_channel("red_out", want.r, red_out);
					check_channel("green_out", want.g, green_out);
					check_channel("blue_out", want.b, blue_out);
				end
			end
		end
	end

	initial begin
		int mode;
		int left;
		tint_ready = 1'b0;
		mode = 0;
		left = 0;
		forever begin
			@(posedge clk);
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(16, 300);
			end
			left--;
			case (mode)
				0:       tint_ready <= 1'b1;
				1:       tint_ready <= ($urandom_range(0, 1) == 1);
				2:       tint_ready <= ($urandom_range(0, 7) != 0);
				default: tint_ready <= ($urandom_range(0, 15) == 0);
			endcase
		end
	end

	task automatic send_tile(tile_t t, bit typed, rgb_t want);
		int gap;
		tile_valid  <= 1'b1;
		tile_up      = 1'b1;
		red_in      <= t.r;
		green_in    <= t.g;
		blue_in     <= t.b;
		tile_flags  <= t.fl;
		stack_count <= t.items;
		spawn_total <= t.spawns;
		tile_house  <= t.hid;
		exp_typed   <= typed;
		exp_rgb     <= want;
		@(posedge clk);
		while (!tile_ready)
			@(posedge clk);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				tile_valid <= 1'b0;
				tile_up     = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain_all();
		if (tile_up) begin
			tile_valid <= 1'b0;
			tile_up     = 1'b0;
		end
		@(posedge clk);
		while (tint_expected.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	task automatic apply_setup(bit blk, bit itm, bit spn, bit hse, bit spc,
			logic [31:0] cur, logic [8:0] pulse);
		drain_all();
		write_reg(CFG_SHOW_BLOCKING, ($urandom() & 32'hFFFF_FFFE) | 32'(blk));
		write_reg(CFG_HIGHLIGHT_ITEMS, ($urandom() & 32'hFFFF_FFFE) | 32'(itm));
		write_reg(CFG_SHOW_SPAWNS, ($urandom() & 32'hFFFF_FFFE) | 32'(spn));
		write_reg(CFG_SHOW_HOUSES, ($urandom() & 32'hFFFF_FFFE) | 32'(hse));
		write_reg(CFG_SHOW_SPECIAL, ($urandom() & 32'hFFFF_FFFE) | 32'(spc));
		write_reg(CFG_CURRENT_HOUSE, cur);
		write_reg(CFG_PULSE_LEVEL, ($urandom() & 32'hFFFF_FE00) | 32'(pulse));
		write_reg(CFG_UNUSED, $urandom());
		cfg_we <= 1'b0;
	endtask

	function automatic void add_row(dir_set_t s, logic [7:0] r, logic [7:0] g, logic [7:0] b,
			logic [7:0] fl, logic [7:0] items, logic [7:0] spawns, logic [31:0] hid,
			bit typed, logic [7:0] er, logic [7:0] eg, logic [7:0] eb);
		dir_row_t row;
		row.t     = '{r: r, g: g, b: b, fl: fl, items: items, spawns: spawns, hid: hid};
		row.setup = s;
		row.typed = typed;
		row.want  = '{r: er, g: eg, b: eb};
		dir_rows.push_back(row);
	endfunction

	function automatic logic [7:0] rand_chan();
		case ($urandom_range(0, 7))
			0:       return 8'd0;
			1:       return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic tile_t rand_tile(logic [31:0] hot);
		tile_t t;
		t.r = rand_chan();
		t.g = rand_chan();
		t.b = rand_chan();
		t.fl = 8'($urandom_range(0, 255));
		t.items = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 10))
			: 8'($urandom_range(0, 255));
		t.spawns = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 12))
			: 8'($urandom_range(0, 255));
		case ($urandom_range(0, 4))
			0:       t.hid = hot;
			1:       t.hid = dim_id;
			2:       t.hid = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
			default: t.hid = $urandom();
		endcase
		return t;
	endfunction

	initial begin
		logic [31:0] h;
		logic [31:0] cur;
		logic [8:0]  pl;
		bit [4:0]    en;
		dir_set_t    active;
		int          k;
		int          n;

		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		tile_valid  = 1'b0;
		red_in      = '0;
		green_in    = '0;
		blue_in     = '0;
		tile_flags  = '0;
		stack_count = '0;
		spawn_total = '0;
		tile_house  = '0;
		exp_typed   = 1'b0;
		exp_rgb     = '0;
		tile_up     = 1'b0;
		burst_left  = 1;
		mismatches  = 0;
		cfg_blocking = 1'b0;
		cfg_items    = 1'b0;
		cfg_spawns   = 1'b0;
		cfg_houses   = 1'b0;
		cfg_special  = 1'b0;
		cfg_house    = '0;
		cfg_pulse    = '0;

		do begin
			dim_id = $urandom();
			h = house_hash(dim_id);
		end while (h[7:0] >= 8'd50 || h[15:8] >= 8'd50 || h[23:16] >= 8'd50);

		add_row(SET_RESET, 8'd0, 8'd0, 8'd0, 8'h00, 8'd0, 8'd0, 32'h0,
			1'b1, 8'd0, 8'd0, 8'd0);
		add_row(SET_RESET, 8'd255, 8'd255, 8'd255, 8'hFF, 8'd255, 8'd255, 32'hFFFF_FFFF,
			1'b1, 8'd255, 8'd255, 8'd255);
		add_row(SET_RESET, 8'hA5, 8'h5A, 8'h3C, 8'h96, 8'h55, 8'hAA, 32'h1234_5678,
			1'b1, 8'hA5, 8'h5A, 8'h3C);
		add_row(SET_FULL, 8'd0, 8'd0, 8'd0, 8'hFF, 8'd255, 8'd255, 32'h0,
			1'b1, 8'd0, 8'd0, 8'd0);
		add_row(SET_FULL, 8'd255, 8'd255, 8'd255, 8'h03, 8'd0, 8'd0, 32'h0,
			1'b1, 8'd255, 8'd170, 8'd170);
		add_row(SET_FULL, 8'd255, 8'd255, 8'd255, 8'h00, 8'd1, 8'd0, 32'h0,
			1'b1, 8'd191, 8'd191, 8'd255);
		add_row(SET_FULL, 8'd255, 8'd255, 8'd255, 8'h00, 8'd200, 8'd0, 32'h0,
			1'b1, 8'd83, 8'd83, 8'd255);
		add_row(SET_FULL, 8'd255, 8'd255, 8'd255, 8'h00, 8'd0, 8'd9, 32'h0,
			1'b1, 8'd255, 8'd9, 8'd9);
		add_row(SET_FULL, 8'd255, 8'd255, 8'd255, 8'h00, 8'd0, 8'd255, 32'h0,
			1'b1, 8'd255, 8'd9, 8'd9);
		add_row(SET_FULL, 8'd255, 8'd255, 8'd255, 8'h04, 8'd3, 8'd0, 32'h0,
			1'b1, 8'd255, 8'd255, 8'd255);
		add_row(SET_FULL, 8'd255, 8'd255, 8'd255, 8'h10, 8'd0, 8'd0, 32'h0,
			1'b1, 8'd127, 8'd255, 8'd127);
		add_row(SET_FULL, 8'd255, 8'd255, 8'd255, 8'h20, 8'd0, 8'd0, 32'h0,
			1'b1, 8'd255, 8'd63, 8'd170);
		add_row(SET_FULL, 8'd255, 8'd255, 8'd255, 8'h40, 8'd0, 8'd0, 32'h0,
			1'b1, 8'd255, 8'd255, 8'd127);
		add_row(SET_FULL, 8'd255, 8'd255, 8'd255, 8'h80, 8'd0, 8'd0, 32'h0,
			1'b1, 8'd255, 8'd127, 8'd255);
		add_row(SET_FULL, 8'd255, 8'd255, 8'd255, 8'h08, 8'd0, 8'd0, 32'h0,
			1'b0, 8'd0, 8'd0, 8'd0);
		add_row(SET_FULL, 8'd255, 8'd255, 8'd255, 8'h18, 8'd0, 8'd0, 32'hFFFF_FFFF,
			1'b0, 8'd0, 8'd0, 8'd0);
		add_row(SET_FULL, 8'd0, 8'd0, 8'd0, 8'h08, 8'd0, 8'd0, 32'hFFFF_FFFF,
			1'b0, 8'd0, 8'd0, 8'd0);
		add_row(SET_FULL, 8'h80, 8'h80, 8'h80, 8'h08, 8'd0, 8'd0, dim_id,
			1'b0, 8'd0, 8'd0, 8'd0);
		add_row(SET_FULL, 8'hC7, 8'h3E, 8'h91, 8'hFF, 8'd2, 8'd4, 32'h0BAD_F00D,
			1'b0, 8'd0, 8'd0, 8'd0);
		add_row(SET_HOT, 8'd255, 8'd255, 8'd255, 8'h08, 8'd0, 8'd0, dim_id,
			1'b0, 8'd0, 8'd0, 8'd0);
		add_row(SET_HOT, 8'd0, 8'd0, 8'd0, 8'h08, 8'd0, 8'd0, dim_id,
			1'b0, 8'd0, 8'd0, 8'd0);
		add_row(SET_HOT, 8'h40, 8'h40, 8'h40, 8'hFB, 8'd5, 8'd1, dim_id,
			1'b0, 8'd0, 8'd0, 8'd0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		active = SET_RESET;
		foreach (dir_rows[i]) begin
			if (dir_rows[i].setup != active) begin
				active = dir_rows[i].setup;
				if (active == SET_FULL)
					apply_setup(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 9'd256);
				else
					apply_setup(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, dim_id, 9'd511);
			end
			send_tile(dir_rows[i].t, dir_rows[i].typed, dir_rows[i].want);
		end

		for (k = 0; k < 8; k++) begin
			case (k)
				0: begin en = 5'b00000; cur = 32'h0;         pl = 9'd0;   end
				1: begin en = 5'b11111; cur = 32'h0;         pl = 9'd511; end
				2: begin en = 5'b11111; cur = 32'hFFFF_FFFF; pl = 9'd256; end
				3: begin en = 5'b11111; cur = $urandom();    pl = 9'd1;   end
				default: begin
					en  = 5'($urandom_range(0, 31));
					cur = $urandom();
					pl  = 9'($urandom_range(0, 511));
				end
			endcase
			apply_setup(en[0], en[1], en[2], en[3], en[4], cur, pl);
			for (n = 0; n < 130; n++) begin
				if (n == 65)
					drain_all();
				send_tile(rand_tile(cur), 1'b0, '0);
			end
		end

		drain_all();
		repeat (16) @(posedge clk);
		if (mismatches == 0 && tint_expected.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
